/* hw/rtl/arq_pkg.sv */
// Shared types, codes and constants of the ARQ timing and congestion controller.
package arq_pkg;

  localparam int OP_W     = 2;
  localparam int RTT_IN_W = 24;
  localparam int WIN_W    = 16;
  localparam int SSTH_W   = 15;
  localparam int RTO_W    = 16;
  localparam int CRED_W   = 32;
  localparam int FI_W     = 13;
  localparam int FR_W     = 8;
  localparam int CFG_DW   = 32;
  localparam int PADDR_W  = 5;
  localparam int IDX_W    = 3;
  // Working width of the credit arithmetic and of the divider numerator.
  localparam int WORK_W   = 34;
  localparam int PROD_W   = 2 * WIN_W + 1;

  localparam logic [OP_W-1:0] OP_RTT   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [RTO_W-1:0]  RTO_LIMIT    = 16'd60000;
  localparam logic [RTO_W-1:0]  RTO_RESET    = 16'd200;
  localparam logic [SSTH_W-1:0] THRESH_FLOOR = 15'd2;

  localparam logic [IDX_W-1:0] REG_FLUSH_INTERVAL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_RTO           = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_SEG_SIZE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_SEND_WINDOW_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_NO_CWND           = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAST_RESEND       = 3'd5;

  localparam logic [FI_W-1:0]  FLUSH_INTERVAL_RESET    = 13'd100;
  localparam logic [RTO_W-1:0] MIN_RTO_RESET           = 16'd100;
  localparam logic [WIN_W-1:0] MAX_SEG_SIZE_RESET      = 16'd1376;
  localparam logic [WIN_W-1:0] SEND_WINDOW_LIMIT_RESET = 16'd32;

  typedef struct packed {
    logic [FI_W-1:0]  flush_interval;
    logic [RTO_W-1:0] min_rto;
    logic [WIN_W-1:0] max_seg_size;
    logic [WIN_W-1:0] send_window_limit;
    logic             no_cwnd;
    logic [FR_W-1:0]  fast_resend;
  } cfg_t;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_RTT_EST,
    STEP_RTT_RTO,
    STEP_ACK_SLOW,
    STEP_ACK_FLOOR,
    STEP_ADD_Q,
    STEP_SET_CW,
    STEP_CAP_MUL,
    STEP_ACK_COMMIT,
    STEP_FL_MUL,
    STEP_FL_COMMIT,
    STEP_EMIT
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     div_q_start;
    logic     div_c_start;
  } dp_cmd_t;

  typedef struct packed {
    logic no_growth;
    logic slow_start;
    logic fits;
    logic div_done;
  } dp_stat_t;

endpackage

/* hw/rtl/arq_if.sv */
// Valid/ready channel interfaces for event beats and result beats.
interface arq_in_if;
  import arq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [RTT_IN_W-1:0] rtt_sample;
  logic [WIN_W-1:0]    remote_window;
  logic [WIN_W-1:0]    inflight;
  logic                fast_retransmit;
  logic                loss;

  modport source (
    output valid, operation, rtt_sample, remote_window, inflight, fast_retransmit, loss,
    input  ready
  );
  modport sink (
    input  valid, operation, rtt_sample, remote_window, inflight, fast_retransmit, loss,
    output ready
  );
endinterface

interface arq_out_if;
  import arq_pkg::*;
  logic              valid;
  logic              ready;
  logic [RTO_W-1:0]  rto;
  logic [WIN_W-1:0]  cwnd;
  logic [SSTH_W-1:0] ssthresh;
  logic [WIN_W-1:0]  send_window;

  modport source (
    output valid, rto, cwnd, ssthresh, send_window,
    input  ready
  );
  modport sink (
    input  valid, rto, cwnd, ssthresh, send_window,
    output ready
  );
endinterface

/* hw/rtl/arq_rto_and_congestion_window.sv */
// Top level of the ARQ sender timing and congestion controller.
// An input beat is taken only in the idle state, so each event runs to its result beat before
// the next one is accepted. An ack in congestion avoidance runs the bit-serial divider once,
// or twice when the window moves, and a result waits while the previous result beat is stalled.
// Synchronous active-low reset restores the register defaults, RTO 200, cwnd 0, ssthresh 2.
module arq_rto_and_congestion_window #(
  parameter int RTT_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arq_in_if.sink                      in_ch,
  arq_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [arq_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [arq_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [arq_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import arq_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  arq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  arq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  arq_dp #(
    .RTT_BITS (RTT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .rtt_sample      (in_ch.rtt_sample),
    .remote_window   (in_ch.remote_window),
    .inflight        (in_ch.inflight),
    .fast_retransmit (in_ch.fast_retransmit),
    .loss            (in_ch.loss),
    .rto             (out_ch.rto),
    .cwnd            (out_ch.cwnd),
    .ssthresh        (out_ch.ssthresh),
    .send_window     (out_ch.send_window)
  );

endmodule

/* hw/rtl/arq_cfg.sv */
// APB-style configuration register file.
module arq_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arq_pkg::PADDR_W-1:0]  paddr,
  input  logic [arq_pkg::CFG_DW-1:0]   pwdata,
  output logic [arq_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output arq_pkg::cfg_t                cfg
);
  import arq_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FLUSH_INTERVAL:    cfg_nxt.flush_interval    = pwdata[FI_W-1:0];
        REG_MIN_RTO:           cfg_nxt.min_rto           = pwdata[RTO_W-1:0];
        REG_MAX_SEG_SIZE:      cfg_nxt.max_seg_size      = pwdata[WIN_W-1:0];
        REG_SEND_WINDOW_LIMIT: cfg_nxt.send_window_limit = pwdata[WIN_W-1:0];
        REG_NO_CWND:           cfg_nxt.no_cwnd           = pwdata[0];
        REG_FAST_RESEND:       cfg_nxt.fast_resend       = pwdata[FR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FLUSH_INTERVAL:    prdata = CFG_DW'(cfg_r.flush_interval);
      REG_MIN_RTO:           prdata = CFG_DW'(cfg_r.min_rto);
      REG_MAX_SEG_SIZE:      prdata = CFG_DW'(cfg_r.max_seg_size);
      REG_SEND_WINDOW_LIMIT: prdata = CFG_DW'(cfg_r.send_window_limit);
      REG_NO_CWND:           prdata = CFG_DW'(cfg_r.no_cwnd);
      REG_FAST_RESEND:       prdata = CFG_DW'(cfg_r.fast_resend);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flush_interval    <= FLUSH_INTERVAL_RESET;
      cfg_r.min_rto           <= MIN_RTO_RESET;
      cfg_r.max_seg_size      <= MAX_SEG_SIZE_RESET;
      cfg_r.send_window_limit <= SEND_WINDOW_LIMIT_RESET;
      cfg_r.no_cwnd           <= 1'b0;
      cfg_r.fast_resend       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/arq_div.sv */
// Restoring divider, one quotient bit per cycle.
module arq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arq_pkg::WORK_W-1:0]  num,
  input  logic [arq_pkg::CRED_W-1:0]  den,
  output logic [arq_pkg::WORK_W-1:0]  quot,
  output logic                        done
);
  import arq_pkg::*;

  localparam int CNT_W = $clog2(WORK_W + 1);

  logic [WORK_W-1:0] quo_r, quo_nxt;
  logic [CRED_W-1:0] rem_r, rem_nxt;
  logic [CRED_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [CRED_W:0]   trial;
  logic              take;

  assign quot = quo_r;
  assign done = done_r;

  always_comb begin
    trial    = {rem_r, quo_r[WORK_W-1]};
    take     = trial >= {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(WORK_W);
    end else if (cnt_r != '0) begin
      // The partial remainder stays below the divisor, so it fits its width.
      rem_nxt  = take ? CRED_W'(trial - {1'b0, den_r}) : trial[CRED_W-1:0];
      quo_nxt  = {quo_r[WORK_W-2:0], take};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

/* hw/rtl/arq_dp.sv */
// Datapath: RTT estimator, congestion state, shared multiplier and divider.
module arq_dp #(
  parameter int RTT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arq_pkg::cfg_t                 cfg,
  input  arq_pkg::dp_cmd_t              cmd,
  output arq_pkg::dp_stat_t             stat,
  input  logic [arq_pkg::RTT_IN_W-1:0]  rtt_sample,
  input  logic [arq_pkg::WIN_W-1:0]     remote_window,
  input  logic [arq_pkg::WIN_W-1:0]     inflight,
  input  logic                          fast_retransmit,
  input  logic                          loss,
  output logic [arq_pkg::RTO_W-1:0]     rto,
  output logic [arq_pkg::WIN_W-1:0]     cwnd,
  output logic [arq_pkg::SSTH_W-1:0]    ssthresh,
  output logic [arq_pkg::WIN_W-1:0]     send_window
);
  import arq_pkg::*;

  localparam int RB = RTT_BITS;

  // Latched event fields.
  logic [RTT_IN_W-1:0] rtt_r, rtt_nxt;
  logic [WIN_W-1:0]    rmt_r, rmt_nxt;
  logic [WIN_W-1:0]    infl_r, infl_nxt;
  logic                fast_r, fast_nxt;
  logic                lost_r, lost_nxt;
  logic [WIN_W-1:0]    win_r, win_nxt;

  // Architectural state.
  logic [RB-1:0]       srtt_r, srtt_nxt;
  logic [RB-1:0]       dev_r, dev_nxt;
  logic [RTO_W-1:0]    rto_r, rto_nxt;
  logic [WIN_W-1:0]    cwnd_r, cwnd_nxt;
  logic [CRED_W-1:0]   credit_r, credit_nxt;
  logic [SSTH_W-1:0]   ssth_r, ssth_nxt;

  // Working registers of the window growth.
  logic [WORK_W-1:0]   cw_w_r, cw_w_nxt;
  logic [WORK_W-1:0]   cr_w_r, cr_w_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;

  // Result registers.
  logic [RTO_W-1:0]    rto_o_r, rto_o_nxt;
  logic [WIN_W-1:0]    cwnd_o_r, cwnd_o_nxt;
  logic [SSTH_W-1:0]   ssth_o_r, ssth_o_nxt;
  logic [WIN_W-1:0]    win_o_r, win_o_nxt;

  logic [RB-1:0]       rtt_c;
  logic [RB-1:0]       delta;
  logic [RB+1:0]       dev_sum;
  logic [RB+2:0]       srtt_sum;
  logic [RB-1:0]       srtt_avg;
  logic [RB+1:0]       margin;
  logic [RB+1:0]       fi_ext;
  logic [RB+1:0]       margin_m;
  logic [RB+2:0]       rto_sum;
  logic [RB+2:0]       min_ext;
  logic [RB+2:0]       rto_lo;
  logic [RTO_W-1:0]    rto_new;

  logic [WIN_W-1:0]    mss;
  logic                mss_nz;
  logic [WIN_W-1:0]    win_lr;
  logic [WIN_W-1:0]    win_in;
  logic [SSTH_W-1:0]   th_fast;
  logic [SSTH_W-1:0]   th_loss;
  logic [WIN_W-1:0]    cw_fast;
  logic                fast_on;

  logic [WIN_W:0]      mul_a;
  logic [WIN_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;

  logic                div_start;
  logic [WORK_W-1:0]   div_num;
  logic [CRED_W-1:0]   div_den;
  logic [WORK_W-1:0]   div_quot;
  logic                div_done;
  logic [WORK_W-1:0]   q_use;
  logic                cw_over;
  logic [CRED_W-1:0]   cr_sat;

  logic [SSTH_W-1:0]   fl_ssth;
  logic [WIN_W-1:0]    fl_cw;
  logic [CRED_W-1:0]   fl_cr;

  generate
    if (RB >= RTT_IN_W) begin : g_rtt_wide
      assign rtt_c = RB'(rtt_r);
    end else begin : g_rtt_sat
      assign rtt_c = (|rtt_r[RTT_IN_W-1:RB]) ? {RB{1'b1}} : rtt_r[RB-1:0];
    end
  endgenerate

  assign mss    = cfg.max_seg_size;
  assign mss_nz = (mss != '0);

  arq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  // RTT estimator and timeout arithmetic.
  always_comb begin
    delta    = (rtt_c >= srtt_r) ? rtt_c - srtt_r : srtt_r - rtt_c;
    dev_sum  = {1'b0, dev_r, 1'b0} + {2'b00, dev_r} + {2'b00, delta};
    srtt_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, rtt_c};
    srtt_avg = srtt_sum[RB+2:3];
    margin   = {dev_r, 2'b00};
    fi_ext   = (RB+2)'(cfg.flush_interval);
    margin_m = (margin < fi_ext) ? fi_ext : margin;
    rto_sum  = {1'b0, margin_m} + {3'b000, srtt_r};
    min_ext  = (RB+3)'(cfg.min_rto);
    rto_lo   = (rto_sum < min_ext) ? min_ext : rto_sum;
    rto_new  = (rto_lo > (RB+3)'(RTO_LIMIT)) ? RTO_LIMIT : rto_lo[RTO_W-1:0];
  end

  // Window and threshold arithmetic.
  always_comb begin
    win_lr  = (cfg.send_window_limit < remote_window) ? cfg.send_window_limit : remote_window;
    win_in  = (!cfg.no_cwnd && cwnd_r < win_lr) ? cwnd_r : win_lr;
    th_fast = (infl_r[WIN_W-1:1] < THRESH_FLOOR) ? THRESH_FLOOR : infl_r[WIN_W-1:1];
    th_loss = (win_r[WIN_W-1:1] < THRESH_FLOOR) ? THRESH_FLOOR : win_r[WIN_W-1:1];
    cw_fast = {1'b0, th_fast} + WIN_W'(cfg.fast_resend);
    fast_on = fast_r && (cfg.fast_resend != '0);
    q_use   = (cr_w_r == '0) ? '0 : div_quot;
    cw_over = cw_w_r > WORK_W'(rmt_r);
    cr_sat  = (|cr_w_r[WORK_W-1:CRED_W]) ? {CRED_W{1'b1}} : cr_w_r[CRED_W-1:0];
  end

  // Shared multiplier; its product is used only after it is registered in prod_r.
  always_comb begin
    case (cmd.step)
      STEP_ACK_FLOOR: mul_a = {1'b0, mss};
      STEP_ADD_Q:     mul_a = {1'b0, cwnd_r} + (WIN_W+1)'(1);
      STEP_CAP_MUL:   mul_a = {1'b0, rmt_r};
      STEP_FL_MUL:    mul_a = {1'b0, cw_fast};
      default:        mul_a = '0;
    endcase
    mul_b = mss;
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Divider operands: first the credit quotient, then the rounded-up window.
  always_comb begin
    div_start = cmd.div_q_start || cmd.div_c_start;
    if (cmd.div_c_start) begin
      div_num = cr_w_r + WORK_W'(mss) - WORK_W'(mss_nz);
      div_den = mss_nz ? CRED_W'(mss) : CRED_W'(1);
    end else begin
      div_num = WORK_W'(prod_r);
      div_den = cr_w_r[CRED_W-1:0];
    end
  end

  // Flush outcome: the loss rule is applied after the fast rule.
  always_comb begin
    fl_ssth = ssth_r;
    fl_cw   = cwnd_r;
    fl_cr   = credit_r;
    if (fast_on) begin
      fl_ssth = th_fast;
      fl_cw   = cw_fast;
      fl_cr   = prod_r[CRED_W-1:0];
    end
    if (lost_r) begin
      fl_ssth = th_loss;
      fl_cw   = WIN_W'(1);
      fl_cr   = CRED_W'(mss);
    end
    if (fl_cw == '0) begin
      fl_cw = WIN_W'(1);
      fl_cr = CRED_W'(mss);
    end
  end

  always_comb begin
    rtt_nxt    = rtt_r;
    rmt_nxt    = rmt_r;
    infl_nxt   = infl_r;
    fast_nxt   = fast_r;
    lost_nxt   = lost_r;
    win_nxt    = win_r;
    srtt_nxt   = srtt_r;
    dev_nxt    = dev_r;
    rto_nxt    = rto_r;
    cwnd_nxt   = cwnd_r;
    credit_nxt = credit_r;
    ssth_nxt   = ssth_r;
    cw_w_nxt   = cw_w_r;
    cr_w_nxt   = cr_w_r;
    prod_nxt   = prod_r;
    rto_o_nxt  = rto_o_r;
    cwnd_o_nxt = cwnd_o_r;
    ssth_o_nxt = ssth_o_r;
    win_o_nxt  = win_o_r;
    case (cmd.step)
      STEP_LOAD: begin
        rtt_nxt  = rtt_sample;
        rmt_nxt  = remote_window;
        infl_nxt = inflight;
        fast_nxt = fast_retransmit;
        lost_nxt = loss;
        win_nxt  = win_in;
      end
      STEP_RTT_EST: begin
        if (srtt_r == '0) begin
          // An empty estimator is seeded by the sample itself.
          srtt_nxt = rtt_c;
          dev_nxt  = rtt_c >> 1;
        end else begin
          dev_nxt  = dev_sum[RB+1:2];
          srtt_nxt = (srtt_avg == '0) ? RB'(1) : srtt_avg;
        end
      end
      STEP_RTT_RTO: begin
        rto_nxt = rto_new;
      end
      STEP_ACK_SLOW: begin
        cw_w_nxt = WORK_W'(cwnd_r) + WORK_W'(1);
        cr_w_nxt = WORK_W'(credit_r) + WORK_W'(mss);
      end
      STEP_ACK_FLOOR: begin
        cw_w_nxt = WORK_W'(cwnd_r);
        cr_w_nxt = (credit_r < CRED_W'(mss)) ? WORK_W'(mss) : WORK_W'(credit_r);
        prod_nxt = mul_p;
      end
      STEP_ADD_Q: begin
        cr_w_nxt = cr_w_r + q_use + WORK_W'(mss[WIN_W-1:4]);
        prod_nxt = mul_p;
      end
      STEP_SET_CW: begin
        cw_w_nxt = div_quot;
      end
      STEP_CAP_MUL: begin
        prod_nxt = mul_p;
      end
      STEP_ACK_COMMIT: begin
        cwnd_nxt   = cw_over ? rmt_r : cw_w_r[WIN_W-1:0];
        credit_nxt = cw_over ? prod_r[CRED_W-1:0] : cr_sat;
      end
      STEP_FL_MUL: begin
        prod_nxt = mul_p;
      end
      STEP_FL_COMMIT: begin
        ssth_nxt   = fl_ssth;
        cwnd_nxt   = fl_cw;
        credit_nxt = fl_cr;
      end
      STEP_EMIT: begin
        rto_o_nxt  = rto_r;
        cwnd_o_nxt = cwnd_r;
        ssth_o_nxt = ssth_r;
        win_o_nxt  = win_r;
      end
      default: ;
    endcase
  end

  assign stat.no_growth  = cwnd_r >= rmt_r;
  assign stat.slow_start = cwnd_r < {1'b0, ssth_r};
  assign stat.fits       = WORK_W'(prod_r) <= cr_w_r;
  assign stat.div_done   = div_done;

  assign rto         = rto_o_r;
  assign cwnd        = cwnd_o_r;
  assign ssthresh    = ssth_o_r;
  assign send_window = win_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r   <= '0;
      dev_r    <= '0;
      rto_r    <= RTO_RESET;
      cwnd_r   <= '0;
      credit_r <= '0;
      ssth_r   <= THRESH_FLOOR;
    end else begin
      srtt_r   <= srtt_nxt;
      dev_r    <= dev_nxt;
      rto_r    <= rto_nxt;
      cwnd_r   <= cwnd_nxt;
      credit_r <= credit_nxt;
      ssth_r   <= ssth_nxt;
    end
    rtt_r    <= rtt_nxt;
    rmt_r    <= rmt_nxt;
    infl_r   <= infl_nxt;
    fast_r   <= fast_nxt;
    lost_r   <= lost_nxt;
    win_r    <= win_nxt;
    cw_w_r   <= cw_w_nxt;
    cr_w_r   <= cr_w_nxt;
    prod_r   <= prod_nxt;
    rto_o_r  <= rto_o_nxt;
    cwnd_o_r <= cwnd_o_nxt;
    ssth_o_r <= ssth_o_nxt;
    win_o_r  <= win_o_nxt;
  end

endmodule

/* hw/rtl/arq_ctrl.sv */
// Controller state machine that sequences the datapath for each event.
module arq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [arq_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  arq_pkg::dp_stat_t        stat,
  output arq_pkg::dp_cmd_t         cmd
);
  import arq_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_RTT_EST    = 4'd1;
  localparam logic [3:0] S_RTT_RTO    = 4'd2;
  localparam logic [3:0] S_ACK_CHK    = 4'd3;
  localparam logic [3:0] S_ACK_DIVQ_GO = 4'd4;
  localparam logic [3:0] S_ACK_DIVQ   = 4'd5;
  localparam logic [3:0] S_ACK_CMP    = 4'd6;
  localparam logic [3:0] S_ACK_DIVC   = 4'd7;
  localparam logic [3:0] S_ACK_CAP    = 4'd8;
  localparam logic [3:0] S_ACK_COMMIT = 4'd9;
  localparam logic [3:0] S_FL_MUL     = 4'd10;
  localparam logic [3:0] S_FL_COMMIT  = 4'd11;
  localparam logic [3:0] S_DONE       = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    cmd.step        = STEP_NONE;
    cmd.div_q_start = 1'b0;
    cmd.div_c_start = 1'b0;
    emit            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = STEP_LOAD;
          case (in_op)
            OP_RTT:   state_nxt = S_RTT_EST;
            OP_ACK:   state_nxt = S_ACK_CHK;
            OP_FLUSH: state_nxt = S_FL_MUL;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_RTT_EST: begin
        cmd.step  = STEP_RTT_EST;
        state_nxt = S_RTT_RTO;
      end
      S_RTT_RTO: begin
        cmd.step  = STEP_RTT_RTO;
        state_nxt = S_DONE;
      end
      S_ACK_CHK: begin
        if (stat.no_growth) begin
          state_nxt = S_DONE;
        end else if (stat.slow_start) begin
          cmd.step  = STEP_ACK_SLOW;
          state_nxt = S_ACK_CAP;
        end else begin
          cmd.step  = STEP_ACK_FLOOR;
          state_nxt = S_ACK_DIVQ_GO;
        end
      end
      S_ACK_DIVQ_GO: begin
        cmd.div_q_start = 1'b1;
        state_nxt       = S_ACK_DIVQ;
      end
      S_ACK_DIVQ: begin
        if (stat.div_done) begin
          cmd.step  = STEP_ADD_Q;
          state_nxt = S_ACK_CMP;
        end
      end
      S_ACK_CMP: begin
        // The window only moves once the credit covers one more segment.
        if (stat.fits) begin
          cmd.div_c_start = 1'b1;
          state_nxt       = S_ACK_DIVC;
        end else begin
          state_nxt = S_ACK_CAP;
        end
      end
      S_ACK_DIVC: begin
        if (stat.div_done) begin
          cmd.step  = STEP_SET_CW;
          state_nxt = S_ACK_CAP;
        end
      end
      S_ACK_CAP: begin
        cmd.step  = STEP_CAP_MUL;
        state_nxt = S_ACK_COMMIT;
      end
      S_ACK_COMMIT: begin
        cmd.step  = STEP_ACK_COMMIT;
        state_nxt = S_DONE;
      end
      S_FL_MUL: begin
        cmd.step  = STEP_FL_MUL;
        state_nxt = S_FL_COMMIT;
      end
      S_FL_COMMIT: begin
        cmd.step  = STEP_FL_COMMIT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result register is reloaded once its previous beat is gone.
        if (!out_valid_r || out_ready) begin
          cmd.step  = STEP_EMIT;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench of the ARQ RTO estimator and congestion window controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 250;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [RTT_IN_W-1:0] rtt_sample;
    logic [WIN_W-1:0]    remote_window;
    logic [WIN_W-1:0]    inflight;
    logic                fast_retransmit;
    logic                loss;
  } event_t;

  typedef struct packed {
    logic [RTO_W-1:0]  rto;
    logic [WIN_W-1:0]  cwnd;
    logic [SSTH_W-1:0] ssthresh;
    logic [WIN_W-1:0]  send_window;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  arq_in_if  in_ch ();
  arq_out_if out_ch ();

  arq_rto_and_congestion_window DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the controller: configuration and estimator/window state.
  cfg_t              cfg;
  bit [RTT_IN_W-1:0] srtt_q;
  bit [RTT_IN_W-1:0] rttvar_q;
  bit [RTO_W-1:0]    rto_q;
  bit [WIN_W-1:0]    cwnd_q;
  bit [CRED_W-1:0]   credit_q;
  bit [SSTH_W-1:0]   ssthresh_q;

  result_t pending_results[$];
  int error_count = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int quiet_left[2] = '{0, 0};

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic bit [CRED_W-1:0] clamp_credit(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[CRED_W-1:0];
  endfunction

  function automatic void fold_rtt_sample(input logic [RTT_IN_W-1:0] sample);
    longint unsigned s, srtt, dev, delta, margin, rto;
    s = sample;
    srtt = srtt_q;
    dev = rttvar_q;
    // A zero smoothed RTT means no sample has been taken yet, so this one seeds.
    if (srtt == 0) begin
      srtt = s;
      dev = s / 2;
    end else begin
      delta = (s >= srtt) ? s - srtt : srtt - s;
      dev = (3 * dev + delta) / 4;
      srtt = (7 * srtt + s) / 8;
      if (srtt < 1) srtt = 1;
    end
    margin = 4 * dev;
    if (margin < cfg.flush_interval) margin = cfg.flush_interval;
    rto = srtt + margin;
    if (rto < cfg.min_rto) rto = cfg.min_rto;
    if (rto > RTO_LIMIT) rto = RTO_LIMIT;
    srtt_q = srtt[RTT_IN_W-1:0];
    rttvar_q = dev[RTT_IN_W-1:0];
    rto_q = rto[RTO_W-1:0];
  endfunction

  function automatic void grow_window(input logic [WIN_W-1:0] remote);
    longint unsigned mss, cw, credit, q, rmt;
    mss = cfg.max_seg_size;
    cw = cwnd_q;
    credit = credit_q;
    rmt = remote;
    if (cw >= rmt) return;
    if (cw < ssthresh_q) begin
      cw++;
      credit += mss;
    end else begin
      if (credit < mss) credit = mss;
      q = (credit != 0) ? (mss * mss) / credit : 0;
      credit += q + mss / 16;
      // With a zero segment size the credit itself becomes the window.
      if ((cw + 1) * mss <= credit) cw = (mss > 0) ? (credit + mss - 1) / mss : credit;
    end
    if (cw > rmt) begin
      cw = rmt;
      credit = rmt * mss;
    end
    cwnd_q = cw[WIN_W-1:0];
    credit_q = clamp_credit(credit);
  endfunction

  function automatic void apply_flush(input logic [WIN_W-1:0] win,
                                      input logic [WIN_W-1:0] inflight,
                                      input logic fast, input logic lost);
    longint unsigned th, cw, mss;
    mss = cfg.max_seg_size;
    if (fast && cfg.fast_resend != 0) begin
      th = inflight / 2;
      if (th < THRESH_FLOOR) th = THRESH_FLOOR;
      ssthresh_q = th[SSTH_W-1:0];
      cw = th + cfg.fast_resend;
      cwnd_q = cw[WIN_W-1:0];
      credit_q = clamp_credit(cw * mss);
    end
    // The loss rule comes second, so it overrides the fast rule.
    if (lost) begin
      th = win / 2;
      if (th < THRESH_FLOOR) th = THRESH_FLOOR;
      ssthresh_q = th[SSTH_W-1:0];
      cwnd_q = 1;
      credit_q = mss[CRED_W-1:0];
    end
    if (cwnd_q == 0) begin
      cwnd_q = 1;
      credit_q = mss[CRED_W-1:0];
    end
  endfunction

  function automatic result_t advance_controller(input event_t ev);
    result_t r;
    logic [WIN_W-1:0] win;
    win = (cfg.send_window_limit < ev.remote_window) ? cfg.send_window_limit
                                                     : ev.remote_window;
    if (!cfg.no_cwnd && cwnd_q < win) win = cwnd_q;
    case (ev.operation)
      OP_RTT:   fold_rtt_sample(ev.rtt_sample);
      OP_ACK:   grow_window(ev.remote_window);
      OP_FLUSH: apply_flush(win, ev.inflight, ev.fast_retransmit, ev.loss);
      default: ;
    endcase
    r.rto = rto_q;
    r.cwnd = cwnd_q;
    r.ssthresh = ssthresh_q;
    r.send_window = win;
    return r;
  endfunction

  // Wait count for one beat; now and then a quiet stretch with no waits at all.
  function automatic int draw_wait(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic event_t make_event(input logic [OP_W-1:0] op,
                                        input logic [RTT_IN_W-1:0] rtt,
                                        input logic [WIN_W-1:0] rmt,
                                        input logic [WIN_W-1:0] inflight,
                                        input logic fast, input logic lost);
    event_t ev;
    ev.operation = op;
    ev.rtt_sample = rtt;
    ev.remote_window = rmt;
    ev.inflight = inflight;
    ev.fast_retransmit = fast;
    ev.loss = lost;
    return ev;
  endfunction

  task automatic send_event(input event_t ev);
    int gap;
    gap = draw_wait(0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= ev.operation;
    in_ch.rtt_sample <= ev.rtt_sample;
    in_ch.remote_window <= ev.remote_window;
    in_ch.inflight <= ev.inflight;
    in_ch.fast_retransmit <= ev.fast_retransmit;
    in_ch.loss <= ev.loss;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results = {pending_results, advance_controller(ev)};
    op_count[ev.operation]++;
  endtask

  // Drops valid in the step of the last accepted beat and waits for every result.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_register(input logic [IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] stored, readback;
    case (idx)
      REG_FLUSH_INTERVAL: begin
        cfg.flush_interval = value[FI_W-1:0];
        stored = CFG_DW'(cfg.flush_interval);
      end
      REG_MIN_RTO: begin
        cfg.min_rto = value[RTO_W-1:0];
        stored = CFG_DW'(cfg.min_rto);
      end
      REG_MAX_SEG_SIZE: begin
        cfg.max_seg_size = value[WIN_W-1:0];
        stored = CFG_DW'(cfg.max_seg_size);
      end
      REG_SEND_WINDOW_LIMIT: begin
        cfg.send_window_limit = value[WIN_W-1:0];
        stored = CFG_DW'(cfg.send_window_limit);
      end
      REG_NO_CWND: begin
        cfg.no_cwnd = value[0];
        stored = CFG_DW'(cfg.no_cwnd);
      end
      default: begin
        cfg.fast_resend = value[FR_W-1:0];
        stored = CFG_DW'(cfg.fast_resend);
      end
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    // Read the register straight back through a second transfer.
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    reg_writes++;
    if (readback !== stored) begin
      $error("register %0d readback mismatch: expected %0d, got %0d", idx, stored, readback);
      error_count++;
    end
  endtask

  // Result side: random stalls on ready, every accepted beat compared in order.
  initial begin
    int stall;
    result_t got, want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(1);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.rto = out_ch.rto;
      got.cwnd = out_ch.cwnd;
      got.ssthresh = out_ch.ssthresh;
      got.send_window = out_ch.send_window;
      if (pending_results.size() == 0) begin
        $error("result beat with no event outstanding: rto %0d cwnd %0d", got.rto, got.cwnd);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.rto !== want.rto) begin
          $error("rto mismatch: expected %0d, got %0d", want.rto, got.rto);
          error_count++;
        end
        if (got.cwnd !== want.cwnd) begin
          $error("cwnd mismatch: expected %0d, got %0d", want.cwnd, got.cwnd);
          error_count++;
        end
        if (got.ssthresh !== want.ssthresh) begin
          $error("ssthresh mismatch: expected %0d, got %0d", want.ssthresh, got.ssthresh);
          error_count++;
        end
        if (got.send_window !== want.send_window) begin
          $error("send_window mismatch: expected %0d, got %0d", want.send_window,
                 got.send_window);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_event(make_event(OP_NONE, '1, '1, '1, 1'b1, 1'b1));
    send_event(make_event(OP_FLUSH, 0, 0, 0, 1'b0, 1'b0));
    send_event(make_event(OP_RTT, 0, 100, 0, 1'b0, 1'b0));
    send_event(make_event(OP_RTT, 0, 100, 0, 1'b0, 1'b0));
    send_event(make_event(OP_RTT, 24'hFFFFFF, 100, 0, 1'b0, 1'b0));
    send_event(make_event(OP_RTT, 1, 100, 0, 1'b0, 1'b0));
    send_event(make_event(OP_ACK, 0, 0, 0, 1'b0, 1'b0));
    repeat (3) send_event(make_event(OP_ACK, 0, 16'hFFFF, 0, 1'b0, 1'b0));
    send_event(make_event(OP_FLUSH, 0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    send_event(make_event(OP_FLUSH, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    program_register(REG_FLUSH_INTERVAL, 32'h1FFF);
    program_register(REG_MIN_RTO, 32'hFFFF);
    program_register(REG_MAX_SEG_SIZE, 32'hFFFF);
    program_register(REG_SEND_WINDOW_LIMIT, 32'hFFFF);
    program_register(REG_NO_CWND, 1);
    program_register(REG_FAST_RESEND, 255);
    send_event(make_event(OP_RTT, 50, 10, 0, 1'b0, 1'b0));
    send_event(make_event(OP_FLUSH, 0, 16'hFFFF, 40, 1'b1, 1'b1));
    send_event(make_event(OP_FLUSH, 0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    send_event(make_event(OP_ACK, 0, 16'hFFFF, 0, 1'b0, 1'b0));
    send_event(make_event(OP_NONE, '1, '1, '1, 1'b1, 1'b1));
    wait_idle();
    program_register(REG_FLUSH_INTERVAL, 0);
    program_register(REG_MIN_RTO, 0);
    program_register(REG_MAX_SEG_SIZE, 0);
    program_register(REG_SEND_WINDOW_LIMIT, 0);
    program_register(REG_NO_CWND, 0);
    program_register(REG_FAST_RESEND, 1);
    send_event(make_event(OP_RTT, 3, 0, 0, 1'b0, 1'b0));
    send_event(make_event(OP_ACK, 0, 16'hFFFF, 0, 1'b0, 1'b0));
    send_event(make_event(OP_FLUSH, 0, 5, 1, 1'b1, 1'b0));
    send_event(make_event(OP_ACK, 0, 10, 0, 1'b0, 1'b0));
  endtask

  task automatic randomize_config();
    logic [CFG_DW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 10;
      1: v = 5000;
      2: v = 32'h1FFF;
      3: v = $urandom_range(0, 8191);
      default: v = $urandom_range(10, 300);
    endcase
    program_register(REG_FLUSH_INTERVAL, v);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = CFG_DW'(RTO_LIMIT);
      2: v = 32'hFFFF;
      3: v = $urandom_range(0, 65535);
      default: v = $urandom_range(50, 1000);
    endcase
    program_register(REG_MIN_RTO, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 26;
      2: v = 65511;
      3: v = 32'hFFFF;
      4: v = $urandom_range(0, 65535);
      default: v = $urandom_range(500, 1500);
    endcase
    program_register(REG_MAX_SEG_SIZE, v);
    case ($urandom_range(0, 5))
      0: v = 1;
      1: v = 32'hFFFF;
      2: v = 0;
      3: v = $urandom_range(0, 65535);
      default: v = $urandom_range(8, 256);
    endcase
    program_register(REG_SEND_WINDOW_LIMIT, v);
    program_register(REG_NO_CWND, ($urandom_range(0, 3) == 0) ? 1 : 0);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 255;
      default: v = $urandom_range(1, 8);
    endcase
    program_register(REG_FAST_RESEND, v);
  endtask

  // Remote windows mostly sit just above the current window so growth is reached.
  function automatic event_t random_event();
    event_t ev;
    int pick, near;
    pick = $urandom_range(0, 99);
    ev.operation = (pick < 30) ? OP_RTT : (pick < 70) ? OP_ACK : (pick < 95) ? OP_FLUSH : OP_NONE;
    case ($urandom_range(0, 5))
      0: ev.rtt_sample = 0;
      1: ev.rtt_sample = '1;
      2: ev.rtt_sample = RTT_IN_W'($urandom);
      default: ev.rtt_sample = RTT_IN_W'($urandom_range(1, 2000));
    endcase
    case ($urandom_range(0, 9))
      0: ev.remote_window = 0;
      1: ev.remote_window = '1;
      2, 3: ev.remote_window = WIN_W'($urandom);
      default: begin
        near = cwnd_q + $urandom_range(0, 24);
        ev.remote_window = (near > 65535) ? 16'hFFFF : near[WIN_W-1:0];
      end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      ev.inflight = WIN_W'($urandom);
    end else begin
      near = $urandom_range(0, 2 * cwnd_q + 8);
      ev.inflight = (near > 65535) ? 16'hFFFF : near[WIN_W-1:0];
    end
    ev.fast_retransmit = ($urandom_range(0, 3) == 0);
    ev.loss = ($urandom_range(0, 4) == 0);
    return ev;
  endfunction

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      randomize_config();
      repeat (BEATS_PER_PHASE) send_event(random_event());
    end
  endtask

  initial begin
    cfg.flush_interval = FLUSH_INTERVAL_RESET;
    cfg.min_rto = MIN_RTO_RESET;
    cfg.max_seg_size = MAX_SEG_SIZE_RESET;
    cfg.send_window_limit = SEND_WINDOW_LIMIT_RESET;
    cfg.no_cwnd = 1'b0;
    cfg.fast_resend = '0;
    srtt_q = '0;
    rttvar_q = '0;
    rto_q = RTO_RESET;
    cwnd_q = '0;
    credit_q = '0;
    ssthresh_q = THRESH_FLOOR;

    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_RTT;
    in_ch.rtt_sample <= '0;
    in_ch.remote_window <= '0;
    in_ch.inflight <= '0;
    in_ch.fast_retransmit <= 1'b0;
    in_ch.loss <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d rtt, %0d ack, %0d flush and %0d unused-op beats across %0d register writes;",
             op_count[0], op_count[1], op_count[2], op_count[3], reg_writes);
    $display("compared %0d result beats field by field, %0d errors.", results_checked,
             error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
